// File: rtl/avg_pool_2d_backward_scatter_defines.svh
// assertion macros used by the checker file of the average-pool backward scatter block
`ifndef AVG_POOL_2D_BACKWARD_SCATTER_DEFINES_SVH
`define AVG_POOL_2D_BACKWARD_SCATTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AVGP_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AVGP_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/avgp_pkg.sv
// shared constants and types of the average-pool backward scatter block
package avgp_pkg;

  // fixed field widths
  localparam int POS_W       = 6;
  localparam int GRAD_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // signed coordinate width, covers pad, stride and dilation ranges
  localparam int CRD_W = 12;

  // reciprocal in q16.16, one over one needs 17 bits
  localparam int RECIP_W = 17;
  localparam int FRAC_W  = 16;
  localparam logic [RECIP_W-1:0] RECIP_ONE = 17'h10000;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_LEFT      = 3'd0,
    REG_PAD_TOP       = 3'd1,
    REG_WINDOW_WIDTH  = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_STEP_X        = 3'd4,
    REG_STEP_Y        = 3'd5,
    REG_SPREAD_X      = 3'd6,
    REG_SPREAD_Y      = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [2:0] PAD_RST    = 3'd0;
  localparam logic [3:0] WINDOW_RST = 4'd2;
  localparam logic [3:0] STEP_RST   = 4'd2;
  localparam logic [2:0] SPREAD_RST = 3'd1;

  // saturation bounds
  localparam logic signed [GRAD_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [GRAD_W-1:0] SAT_MIN = 32'sh80000000;

endpackage

// File: rtl/avgp_ram.sv
// generic single-write, single-read ram with registered read data
module avgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/avgp_recip.sv
// iterative reciprocal unit, one quotient bit per cycle, q16.16 rounded to nearest
module avgp_recip #(
  parameter int NW = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [NW-1:0]                divisor,
  output logic                         done,
  output logic [avgp_pkg::RECIP_W-1:0] quot
);

  localparam int RW = avgp_pkg::RECIP_W;
  localparam int SW = $clog2(RW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] cnt_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] rem_r;
  logic [RW-1:0] num_r;
  logic [RW-1:0] quot_r;

  logic [NW:0] rem_sh;
  logic [NW:0] rem_dif;
  logic        fits;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, num_r[RW-1]};
  assign fits    = (rem_sh >= {1'b0, n_r});
  assign rem_dif = rem_sh - {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // numerator is one plus half the divisor, for round to nearest
      num_r  <= avgp_pkg::RECIP_ONE + RW'(divisor >> 1);
      n_r    <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? rem_dif[NW-1:0] : rem_sh[NW-1:0];
      num_r  <= {num_r[RW-2:0], 1'b0};
      quot_r <= {quot_r[RW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: rtl/avg_pool_2d_backward_scatter.sv
// top level of the average-pool backward scatter block
//
// Average-pool backward pass over one gradient plane of PLANE_WIDTH x PLANE_HEIGHT signed
// q16.16 entries, held in a single-port-write ram. After reset the block sweeps the ram to
// zero, one entry per cycle, and in_tready stays low until the sweep ends; configuration
// writes are taken during the sweep. A scatter transaction (in_tuser low) places the window
// at pos*step - pad, clips the undilated window to the plane to get the pixel count, runs
// an iterative divider for 1/count in q16.16 (17 quotient bits, one a cycle), scales the
// gradient with one 32x18 multiply, then walks the window taps one per cycle through a
// single read-modify-write adder with saturation and a one-deep forwarding register, so
// coinciding taps add correctly. A scatter holds in_tready low through all ww*wh taps, ww
// and wh being the window size clamped to MAX_WINDOW, since the tap walk goes through the
// one ram write port. A scatter whose clipped count is zero returns to idle from the count
// state without a divide. A read transaction (in_tuser high) reads and clears the entry at
// (pos_x, pos_y) in the read state, then in the read-out state waits for a free output
// register and presents the old entry, or returns zero if the position lies off the plane;
// the result sits in an output register, and a new transaction is taken while it waits,
// but a second read cannot finish until the first result is taken. One transaction is in
// work at a time; in_tready is high only when the sequencer is idle.
module avg_pool_2d_backward_scatter #(
  parameter int PLANE_WIDTH  = 64,
  parameter int PLANE_HEIGHT = 64,
  parameter int MAX_WINDOW   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [avgp_pkg::IN_TDATA_W-1:0]     in_tdata,   // pos_x, pos_y, grad_value, zero pad
  input  logic                                in_tuser,   // mode
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [avgp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // plane_value
  // configuration port
  input  logic                                cfg_we,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [avgp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = PLANE_WIDTH * PLANE_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = avgp_pkg::CRD_W;
  localparam int LW     = AW + CW;
  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int NW     = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int GW     = avgp_pkg::GRAD_W;
  localparam int PW     = avgp_pkg::POS_W;
  localparam int PROD_W = GW + avgp_pkg::RECIP_W + 1;
  localparam int FW     = avgp_pkg::FRAC_W;

  localparam logic signed [CW-1:0] PW_S = CW'(PLANE_WIDTH);
  localparam logic signed [CW-1:0] PH_S = CW'(PLANE_HEIGHT);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_SETUP = 10'b00_0000_0100,
    S_COUNT = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_SCALE = 10'b00_0010_0000,
    S_TAP   = 10'b00_0100_0000,
    S_DRAIN = 10'b00_1000_0000,
    S_RD    = 10'b01_0000_0000,
    S_RDOUT = 10'b10_0000_0000
  } state_t;

  // clipped extent of a window along one axis
  function automatic logic [KW-1:0] extent(input logic signed [CW-1:0] start,
                                           input logic [KW-1:0]        win,
                                           input logic signed [CW-1:0] limit);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] dif;
    hi  = start + $signed(CW'(win));
    lo  = (start < 0) ? '0 : start;
    if (hi > limit) begin
      hi = limit;
    end
    dif = hi - lo;
    return (hi > lo) ? dif[KW-1:0] : '0;
  endfunction

  state_t state_r;
  state_t state_nxt;

  // configuration registers
  logic [2:0] pad_left_r;
  logic [2:0] pad_top_r;
  logic [3:0] window_width_r;
  logic [3:0] window_height_r;
  logic [3:0] step_x_r;
  logic [3:0] step_y_r;
  logic [2:0] spread_x_r;
  logic [2:0] spread_y_r;

  // captured transaction
  logic [PW-1:0]        px_r;
  logic [PW-1:0]        py_r;
  logic signed [GW-1:0] g_r;

  // window geometry
  logic signed [CW-1:0] sx_r;
  logic signed [CW-1:0] sy_r;
  logic [KW-1:0]        ww_r;
  logic [KW-1:0]        wh_r;
  logic [KW-1:0]        kx_r;
  logic [KW-1:0]        ky_r;
  logic signed [CW-1:0] col_r;
  logic signed [CW-1:0] row_r;

  // scaling
  logic signed [PROD_W-1:0] prod_r;
  logic signed [GW-1:0]     q_r;

  // clearing sweep
  logic [AW-1:0] clr_r;

  // accumulate stage and forwarding of the last write
  logic          p1_valid_r;
  logic [AW-1:0] p1_addr_r;
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [GW-1:0] fwd_data_r;

  // read path and result register
  logic          rd_hit_r;
  logic          out_valid_r;
  logic [GW-1:0] out_data_r;

  logic in_acc;
  logic out_free;

  // setup arithmetic
  logic [9:0]           sx_mul;
  logic [9:0]           sy_mul;
  logic [KW-1:0]        ww_clamp;
  logic [KW-1:0]        wh_clamp;
  logic [KW-1:0]        cw;
  logic [KW-1:0]        ch;
  logic [NW-1:0]        count;
  logic                 recip_start;
  logic                 recip_done;
  logic [avgp_pkg::RECIP_W-1:0] recip_quot;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [PROD_W-1:0]     prod_rnd;

  // tap walk
  logic          tap_ok;
  logic          tap_last;
  logic          row_end;
  logic [LW-1:0] tap_lin;
  logic [LW-1:0] rd_lin;
  logic          rd_in_plane;

  // accumulate
  logic [GW-1:0]        ram_rdata;
  logic signed [GW-1:0] acc_old;
  logic signed [GW:0]   acc_sum;
  logic signed [GW-1:0] acc_sat;

  // ram ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [GW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_left_r      <= avgp_pkg::PAD_RST;
      pad_top_r       <= avgp_pkg::PAD_RST;
      window_width_r  <= avgp_pkg::WINDOW_RST;
      window_height_r <= avgp_pkg::WINDOW_RST;
      step_x_r        <= avgp_pkg::STEP_RST;
      step_y_r        <= avgp_pkg::STEP_RST;
      spread_x_r      <= avgp_pkg::SPREAD_RST;
      spread_y_r      <= avgp_pkg::SPREAD_RST;
    end else if (cfg_we) begin
      unique case (avgp_pkg::cfg_reg_t'(cfg_addr))
        avgp_pkg::REG_PAD_LEFT:      pad_left_r      <= cfg_wdata[2:0];
        avgp_pkg::REG_PAD_TOP:       pad_top_r       <= cfg_wdata[2:0];
        avgp_pkg::REG_WINDOW_WIDTH:  window_width_r  <= cfg_wdata;
        avgp_pkg::REG_WINDOW_HEIGHT: window_height_r <= cfg_wdata;
        avgp_pkg::REG_STEP_X:        step_x_r        <= cfg_wdata;
        avgp_pkg::REG_STEP_Y:        step_y_r        <= cfg_wdata;
        avgp_pkg::REG_SPREAD_X:      spread_x_r      <= cfg_wdata[2:0];
        avgp_pkg::REG_SPREAD_Y:      spread_y_r      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- window setup
  // stride multiply is small; window size above the maximum is clamped
  assign sx_mul   = 10'(px_r) * 10'(step_x_r);
  assign sy_mul   = 10'(py_r) * 10'(step_y_r);
  assign ww_clamp = (32'(window_width_r) > MAX_WINDOW)  ? KW'(MAX_WINDOW) : KW'(window_width_r);
  assign wh_clamp = (32'(window_height_r) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(window_height_r);

  // pixel count ignores dilation; it never exceeds the reciprocal range
  assign cw    = extent(sx_r, ww_r, PW_S);
  assign ch    = extent(sy_r, wh_r, PH_S);
  assign count = NW'((2 * KW)'(cw) * (2 * KW)'(ch));

  assign recip_start = (state_r == S_COUNT) && (count != '0);

  avgp_recip #(
    .NW (NW)
  ) u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start),
    .divisor (count),
    .done    (recip_done),
    .quot    (recip_quot)
  );

  // gradient times reciprocal, then round to q16.16 by adding half and flooring
  assign prod_nxt = PROD_W'(g_r) * PROD_W'($signed({1'b0, recip_quot}));
  assign prod_rnd = prod_r + PROD_W'(32'sd32768);

  // ---------------------------------------------------------------- tap walk
  assign tap_ok   = (row_r >= 0) && (row_r < PH_S) && (col_r >= 0) && (col_r < PW_S);
  assign row_end  = (kx_r == ww_r - KW'(1));
  assign tap_last = row_end && (ky_r == wh_r - KW'(1));
  assign tap_lin  = LW'(row_r[CW-2:0]) * LW'(PLANE_WIDTH) + LW'(col_r[CW-2:0]);

  // read transaction address
  assign rd_in_plane = (32'(px_r) < PLANE_WIDTH) && (32'(py_r) < PLANE_HEIGHT);
  assign rd_lin      = LW'(py_r) * LW'(PLANE_WIDTH) + LW'(px_r);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? S_RD : S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_COUNT;
      S_COUNT: state_nxt = (count != '0) ? S_DIV : S_IDLE;
      S_DIV: begin
        if (recip_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: state_nxt = S_TAP;
      S_TAP: begin
        if (tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_IDLE;
      S_RD:    state_nxt = S_RDOUT;
      S_RDOUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      p1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_valid_r  <= (state_r == S_TAP) && tap_ok;
      fwd_valid_r <= wr_en;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if ((state_r == S_RDOUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_tdata[PW-1:0];
      py_r <= in_tdata[2*PW-1:PW];
      g_r  <= $signed(in_tdata[2*PW+GW-1:2*PW]);
    end
    if (state_r == S_SETUP) begin
      sx_r <= $signed(CW'(sx_mul)) - $signed(CW'(pad_left_r));
      sy_r <= $signed(CW'(sy_mul)) - $signed(CW'(pad_top_r));
      ww_r <= ww_clamp;
      wh_r <= wh_clamp;
    end
    if (state_r == S_COUNT) begin
      col_r <= sx_r;
      row_r <= sy_r;
      kx_r  <= '0;
      ky_r  <= '0;
    end
    if ((state_r == S_DIV) && recip_done) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_SCALE) begin
      q_r <= prod_rnd[FW+GW-1:FW];
    end
    if (state_r == S_TAP) begin
      if (row_end) begin
        kx_r  <= '0;
        ky_r  <= ky_r + KW'(1);
        col_r <= sx_r;
        row_r <= row_r + $signed(CW'(spread_y_r));
      end else begin
        kx_r  <= kx_r + KW'(1);
        col_r <= col_r + $signed(CW'(spread_x_r));
      end
    end
    p1_addr_r  <= tap_lin[AW-1:0];
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
    if (state_r == S_RD) begin
      rd_hit_r <= rd_in_plane;
    end
    if ((state_r == S_RDOUT) && out_free) begin
      out_data_r <= rd_hit_r ? ram_rdata : '0;
    end
  end

  // ---------------------------------------------------------------- accumulate
  // the word written last cycle is not yet in the ram read data
  assign acc_old = (fwd_valid_r && (fwd_addr_r == p1_addr_r)) ? $signed(fwd_data_r)
                                                              : $signed(ram_rdata);
  assign acc_sum = (GW + 1)'(acc_old) + (GW + 1)'(q_r);
  assign acc_sat = (acc_sum[GW] == acc_sum[GW-1]) ? acc_sum[GW-1:0]
                 : (acc_sum[GW] ? avgp_pkg::SAT_MIN : avgp_pkg::SAT_MAX);

  // ---------------------------------------------------------------- ram port selection
  always_comb begin
    rd_en   = (state_r == S_TAP) && tap_ok;
    rd_addr = tap_lin[AW-1:0];
    wr_en   = p1_valid_r;
    wr_addr = p1_addr_r;
    wr_data = acc_sat;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r == S_RD) begin
      // read old word and clear it in the same cycle
      rd_en   = rd_in_plane;
      rd_addr = rd_lin[AW-1:0];
      wr_en   = rd_in_plane;
      wr_addr = rd_lin[AW-1:0];
      wr_data = '0;
    end
  end

  avgp_ram #(
    .WIDTH (GW),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/avgp_chk.sv
// port-level checker of the average-pool backward scatter block, bound to the top level
`include "avg_pool_2d_backward_scatter_defines.svh"

module avgp_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [avgp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result keeps its value
  `AVGP_CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one transaction at a time: ready drops right after an accept
  `AVGP_CHK_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "ready high after accept")

  // the clearing sweep holds off input after reset
  `AVGP_CHK_SAME(a_clear_after_reset, $rose(rst_n), !in_tready, "ready high during clearing sweep")

  // a result only appears out of a busy read sequence
  `AVGP_CHK_SAME(a_result_from_read, $rose(out_tvalid), !$past(in_tready), "result without a read")

endmodule

bind avg_pool_2d_backward_scatter avgp_chk u_avgp_chk (.*);
